// File: rtl/fpcc_pkg.sv
// Shared types and constants of the feature pair coincidence counter.
// No dependencies; every other file of the block imports this package.
package fpcc_pkg;

    localparam int FEAT_W         = 6;
    localparam int MAX_FEATURES   = 1 << FEAT_W;
    localparam int CFG_W          = 7;
    localparam int MAX_ROW_ACTIVE = 32;
    localparam int ROW_IDX_W      = (MAX_ROW_ACTIVE > 1) ? $clog2(MAX_ROW_ACTIVE) : 1;
    localparam int FILL_W         = $clog2(MAX_ROW_ACTIVE + 1);
    localparam int ADDR_W         = 2 * FEAT_W;
    localparam int MEM_DEPTH      = 1 << ADDR_W;
    localparam int COUNT_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_LONG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_READ = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    // One classified request as handed from the front to the back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [FEAT_W-1:0] a;
        logic [FEAT_W-1:0] b;
        logic [FILL_W-1:0] fill;
        status_t           status;
    } cmd_t;

endpackage

// File: rtl/feature_pair_coincidence_counter_top.sv
// Feature pair coincidence counter, top level: front, request queue, back.
// A read or error request passes the queue entry, the update stage and the result register
// before out_valid rises. Throughput: the back runs one count update per cycle on the count
// store (one read port, one write port); an add with n features held issues one update for
// its own pair and two for each held feature (n up to 31).
// Reset: row and queue cleared at once; the count store is zeroed by a sweep over all 4096
// entries, during which in_stall is high. Configuration writes are taken at any time.
module feature_pair_coincidence_counter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [fpcc_pkg::FEAT_W-1:0]   feature,
    input  logic                          row_end,
    input  logic [fpcc_pkg::FEAT_W-1:0]   read_first,
    input  logic [fpcc_pkg::FEAT_W-1:0]   read_second,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fpcc_pkg::STATUS_W-1:0] status,
    output logic [fpcc_pkg::COUNT_W-1:0]  count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpcc_pkg::CFG_W-1:0]    cfg_data
);
    import fpcc_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clearing;

    fpcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .feature     (feature),
        .row_end     (row_end),
        .read_first  (read_first),
        .read_second (read_second),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    fpcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    fpcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count)
    );

endmodule

// File: rtl/fpcc_front.sv
// Front end: takes requests, checks indices and row length, keeps the row fill count.
// Depends on fpcc_pkg; feeds fpcc_queue.
module fpcc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [fpcc_pkg::FEAT_W-1:0] feature,
    input  logic                       row_end,
    input  logic [fpcc_pkg::FEAT_W-1:0] read_first,
    input  logic [fpcc_pkg::FEAT_W-1:0] read_second,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fpcc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       clearing,
    input  logic                       q_full,
    output logic                       q_push,
    output fpcc_pkg::cmd_t             q_cmd
);
    import fpcc_pkg::*;

    logic [CFG_W-1:0]  matrix_size_reg;
    logic [FILL_W-1:0] row_fill_reg;
    logic [FILL_W-1:0] row_fill_next;
    logic [CFG_W-1:0]  lim;
    logic              accept;
    logic              feat_ok;
    logic              pair_ok;
    logic              row_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full || clearing;
    assign accept    = in_valid && !in_stall;
    assign q_push    = accept;

    assign lim      = (matrix_size_reg > CFG_W'(MAX_FEATURES)) ? CFG_W'(MAX_FEATURES)
                                                               : matrix_size_reg;
    assign feat_ok  = CFG_W'(feature) < lim;
    assign pair_ok  = (CFG_W'(read_first) < lim) && (CFG_W'(read_second) < lim);
    assign row_full = row_fill_reg >= FILL_W'(MAX_ROW_ACTIVE);

    always_comb
    begin
        q_cmd         = '0;
        q_cmd.kind    = CMD_ERR;
        q_cmd.status  = STAT_RANGE;
        row_fill_next = row_fill_reg;
        if (op)
        begin
            q_cmd.a = read_first;
            q_cmd.b = read_second;
            if (pair_ok)
            begin
                q_cmd.kind   = CMD_READ;
                q_cmd.status = STAT_OK;
            end
        end
        else
        begin
            q_cmd.a    = feature;
            q_cmd.fill = row_fill_reg;
            if (!feat_ok)
            begin
                q_cmd.status = STAT_RANGE;
            end
            else if (row_full)
            begin
                q_cmd.status = STAT_LONG;
            end
            else
            begin
                q_cmd.kind    = CMD_ADD;
                q_cmd.status  = STAT_OK;
                row_fill_next = row_fill_reg + FILL_W'(1);
            end
            // a row end clears the row even after a failed add
            if (row_end)
            begin
                row_fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= SIZE_RESET;
            row_fill_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                matrix_size_reg <= cfg_data;
            end
            if (accept)
            begin
                row_fill_reg <= row_fill_next;
            end
        end
    end

endmodule

// File: rtl/fpcc_queue.sv
// Short request queue between the front and the back.
// Depends on fpcc_pkg for the request type and depth.
module fpcc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpcc_pkg::cmd_t push_cmd,
    input  logic           pop,
    output fpcc_pkg::cmd_t head_cmd,
    output logic           full,
    output logic           empty
);
    import fpcc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/fpcc_back.sv
// Back end: clears the count store, runs the pair count updates, serves reads and results.
// Depends on fpcc_pkg; drains fpcc_queue and drives the result channel.
module fpcc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpcc_pkg::cmd_t                head_cmd,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fpcc_pkg::STATUS_W-1:0] status,
    output logic [fpcc_pkg::COUNT_W-1:0]  count
);
    import fpcc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BUMP  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   mem [MEM_DEPTH];
    logic [FEAT_W-1:0]    row_feat_reg [MAX_ROW_ACTIVE];

    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [FEAT_W-1:0]    cur_feat_reg, cur_feat_next;
    logic [FILL_W-1:0]    cur_fill_reg, cur_fill_next;
    logic [ROW_IDX_W-1:0] k_reg, k_next;
    logic                 phase_reg, phase_next;

    // update stage: holds a request together with its registered memory read data
    logic                 p1_valid_reg;
    logic                 p1_res_reg;
    logic                 p1_read_reg;
    logic [ADDR_W-1:0]    p1_addr_reg;
    status_t              p1_status_reg;

    logic [COUNT_W-1:0]   rdata_reg;
    logic                 last_wen_reg;
    logic [ADDR_W-1:0]    last_waddr_reg;
    logic [COUNT_W-1:0]   last_wdata_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic                 iss_valid;
    logic                 iss_res;
    logic                 iss_read;
    logic [ADDR_W-1:0]    iss_addr;
    status_t              iss_status;
    logic                 row_wen;
    logic [FEAT_W-1:0]    g;
    logic                 k_last;
    logic                 res_slot_ok;
    logic [COUNT_W-1:0]   src;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [COUNT_W-1:0]   wr_data;

    assign clearing    = state_reg == ST_CLEAR;
    assign g           = row_feat_reg[k_reg];
    assign k_last      = FILL_W'(k_reg) == (cur_fill_reg - FILL_W'(1));
    // only one result in flight, and the output must be free when it lands
    assign res_slot_ok = (!out_valid_reg || !out_stall) && !(p1_valid_reg && p1_res_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_feat_next = cur_feat_reg;
        cur_fill_next = cur_fill_reg;
        k_next        = k_reg;
        phase_next    = phase_reg;
        iss_valid     = 1'b0;
        iss_res       = 1'b0;
        iss_read      = 1'b0;
        iss_addr      = {head_cmd.a, head_cmd.b};
        iss_status    = head_cmd.status;
        q_pop         = 1'b0;
        row_wen       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (head_cmd.kind)
                        CMD_ADD:
                        begin
                            q_pop         = 1'b1;
                            row_wen       = 1'b1;
                            iss_valid     = 1'b1;
                            iss_addr      = {head_cmd.a, head_cmd.a};
                            cur_feat_next = head_cmd.a;
                            cur_fill_next = head_cmd.fill;
                            k_next        = '0;
                            phase_next    = 1'b0;
                            if (head_cmd.fill != '0)
                            begin
                                state_next = ST_BUMP;
                            end
                        end
                        CMD_READ:
                        begin
                            if (res_slot_ok)
                            begin
                                q_pop     = 1'b1;
                                iss_valid = 1'b1;
                                iss_res   = 1'b1;
                                iss_read  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (res_slot_ok)
                            begin
                                q_pop     = 1'b1;
                                iss_valid = 1'b1;
                                iss_res   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_BUMP:
            begin
                iss_valid = 1'b1;
                if (!phase_reg)
                begin
                    iss_addr   = {cur_feat_reg, g};
                    phase_next = 1'b1;
                end
                else
                begin
                    iss_addr   = {g, cur_feat_reg};
                    phase_next = 1'b0;
                    k_next     = k_reg + ROW_IDX_W'(1);
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // take the value written last cycle when the read raced with it
    assign src = (last_wen_reg && (last_waddr_reg == p1_addr_reg)) ? last_wdata_reg
                                                                    : rdata_reg;

    always_comb
    begin
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = p1_valid_reg && !p1_res_reg;
            wr_addr = p1_addr_reg;
            wr_data = (src == {COUNT_W{1'b1}}) ? src : src + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (row_wen)
        begin
            row_feat_reg[head_cmd.fill[ROW_IDX_W-1:0]] <= head_cmd.a;
        end
        last_waddr_reg <= wr_addr;
        last_wdata_reg <= wr_data;
        p1_addr_reg    <= iss_addr;
        p1_status_reg  <= iss_status;
        p1_read_reg    <= iss_read;
        p1_res_reg     <= iss_res;
        cur_feat_reg   <= cur_feat_next;
        cur_fill_reg   <= cur_fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            last_wen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            phase_reg    <= phase_next;
            p1_valid_reg <= iss_valid;
            last_wen_reg <= wr_en;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (p1_valid_reg && p1_res_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg && p1_res_reg)
        begin
            status_reg <= p1_status_reg;
            count_reg  <= p1_read_reg ? src : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;

endmodule

// File: tb/sv/fpcc_tb_pkg.sv
// Request opcode shared by the stimulus top and the checker of the
// feature pair coincidence counter testbench. No dependencies.
`timescale 1ns / 1ps
package fpcc_tb_pkg;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } op_kind_t;

endpackage

// File: tb/sv/fpcc_checker.sv
// Checker for the feature pair coincidence counter: watches the request, result and
// size-register channels, predicts results and compares them in order.
// Depends on fpcc_pkg (RTL) and fpcc_tb_pkg.
`timescale 1ns / 1ps
module fpcc_checker
    import fpcc_pkg::*;
    import fpcc_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                op,
    input  logic [FEAT_W-1:0]   feature,
    input  logic                row_end,
    input  logic [FEAT_W-1:0]   read_first,
    input  logic [FEAT_W-1:0]   read_second,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  count,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  fail_cnt,
    output int                  replies_due
);

    typedef struct {
        status_t            status;
        logic [COUNT_W-1:0] count;
    } pair_reply_t;

    logic [COUNT_W-1:0] pair_tally [MEM_DEPTH];
    logic [FEAT_W-1:0]  held_feats [MAX_ROW_ACTIVE];
    int                 held_fill;
    logic [CFG_W-1:0]   feat_limit;
    pair_reply_t        due_replies [$];

    function automatic void flag_miss(string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("fpcc mismatch at %0t: %s", $time, msg);
    endfunction

    function automatic void bump_pair(logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
        // saturate instead of wrapping
        if (pair_tally[{a, b}] != '1)
            pair_tally[{a, b}] = pair_tally[{a, b}] + COUNT_W'(1);
    endfunction

    function automatic void tally_request(logic o, logic [FEAT_W-1:0] f, logic re,
                                          logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
        int          lim;
        pair_reply_t r;
        lim = (feat_limit > MAX_FEATURES) ? MAX_FEATURES : int'(feat_limit);
        if (o == OP_READ) begin
            if (a >= lim || b >= lim) begin
                r.status = STAT_RANGE;
                r.count  = '0;
            end
            else begin
                r.status = STAT_OK;
                r.count  = pair_tally[{a, b}];
            end
            due_replies.push_back(r);
            return;
        end
        if (f >= lim) begin
            r.status = STAT_RANGE;
            r.count  = '0;
            due_replies.push_back(r);
        end
        else if (held_fill >= MAX_ROW_ACTIVE) begin
            r.status = STAT_LONG;
            r.count  = '0;
            due_replies.push_back(r);
        end
        else begin
            bump_pair(f, f);
            for (int k = 0; k < held_fill; k++) begin
                bump_pair(f, held_feats[k]);
                bump_pair(held_feats[k], f);
            end
            held_feats[held_fill] = f;
            held_fill++;
        end
        // a row end clears the row even when the add failed
        if (re)
            held_fill = 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pair_reply_t want;
        if (!rst_n) begin
            foreach (pair_tally[i])
                pair_tally[i] = '0;
            foreach (held_feats[i])
                held_feats[i] = '0;
            held_fill  = 0;
            feat_limit = SIZE_RESET;
            due_replies.delete();
            replies_due = 0;
            fail_cnt    = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (due_replies.size() == 0) begin
                    flag_miss($sformatf("result with none due: status %0d count %0d",
                                        status, count));
                end
                else begin
                    want = due_replies.pop_front();
                    if (status !== want.status)
                        flag_miss($sformatf("status %0d, expected %0d", status, want.status));
                    if (count !== want.count)
                        flag_miss($sformatf("count %0d, expected %0d", count, want.count));
                end
            end
            if (cfg_valid && cfg_ready)
                feat_limit = cfg_data;
            if (in_valid && !in_stall)
                tally_request(op, feature, row_end, read_first, read_second);
            replies_due = due_replies.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for feature_pair_coincidence_counter_top: drives requests, size writes
// and result back-pressure, and gives the verdict from the checker's failure count.
// Depends on fpcc_pkg, fpcc_tb_pkg, fpcc_checker and the RTL top.
`timescale 1ns / 1ps
module tb_top;
    import fpcc_pkg::*;
    import fpcc_tb_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 250;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [FEAT_W-1:0]   feature;
    logic                row_end;
    logic [FEAT_W-1:0]   read_first;
    logic [FEAT_W-1:0]   read_second;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    int                  fail_cnt;
    int                  replies_due;

    int                  in_gap_pct;
    int                  out_gap_pct;
    logic                hold_off;
    logic                hold_done;
    int                  size_now;
    int                  rows_made;

    feature_pair_coincidence_counter_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .feature     (feature),
        .row_end     (row_end),
        .read_first  (read_first),
        .read_second (read_second),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .count       (count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    fpcc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .feature     (feature),
        .row_end     (row_end),
        .read_first  (read_first),
        .read_second (read_second),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .count       (count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_cnt    (fail_cnt),
        .replies_due (replies_due)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("feature_pair_coincidence_counter_top test failed");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off && !hold_done) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_stall = ($urandom_range(0, 99) < out_gap_pct);
        end
    end

    task automatic push_req(logic o, logic [FEAT_W-1:0] f, logic re,
                            logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        op          = o;
        feature     = f;
        row_end     = re;
        read_first  = a;
        read_second = b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic add_feat(logic [FEAT_W-1:0] f, logic re);
        push_req(OP_ADD, f, re, FEAT_W'($urandom), FEAT_W'($urandom));
    endtask

    task automatic read_pair(logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
        push_req(OP_READ, FEAT_W'($urandom), 1'($urandom), a, b);
    endtask

    // drain results and let a trailing add finish before touching the register
    task automatic settle();
        in_valid = 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(int v);
        cfg_valid = 1'b1;
        cfg_data  = CFG_W'(v);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        size_now  = v;
    endtask

    function automatic logic [FEAT_W-1:0] pick_feat();
        int lim;
        lim = (size_now > MAX_FEATURES) ? MAX_FEATURES : size_now;
        if (lim == 0 || $urandom_range(0, 99) < 8)
            return FEAT_W'($urandom);
        return FEAT_W'($urandom_range(0, lim - 1));
    endfunction

    // mostly well-formed rows with reads mixed in, plus some noise requests
    task automatic run_rows(int n_items);
        int               sent;
        int               row_len;
        logic [FEAT_W-1:0] f;
        logic [FEAT_W-1:0] row_seen [$];
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                push_req(1'($urandom), FEAT_W'($urandom), 1'($urandom),
                         FEAT_W'($urandom), FEAT_W'($urandom));
                sent++;
            end
            else begin
                rows_made++;
                // every tenth row overruns the row limit
                row_len = (rows_made % 10 == 3) ? $urandom_range(MAX_ROW_ACTIVE + 1,
                                                                 MAX_ROW_ACTIVE + 4)
                                                : $urandom_range(1, 8);
                row_seen.delete();
                for (int k = 0; k < row_len; k++) begin
                    f = pick_feat();
                    row_seen.push_back(f);
                    add_feat(f, k == row_len - 1);
                    sent++;
                    if ($urandom_range(0, 99) < 35) begin
                        read_pair(($urandom_range(0, 3) == 0) ? pick_feat()
                                      : row_seen[$urandom_range(0, row_seen.size() - 1)],
                                  row_seen[$urandom_range(0, row_seen.size() - 1)]);
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_ADD;
        feature     = '0;
        row_end     = 1'b0;
        read_first  = '0;
        read_second = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_off    = 1'b0;
        in_gap_pct  = 6;
        out_gap_pct = 77;
        size_now    = int'(SIZE_RESET);
        rows_made   = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // empty store, repeated feature in a row, single-feature row
        read_pair(0, 0);
        read_pair(63, 63);
        add_feat(0, 1'b0);
        add_feat(63, 1'b0);
        add_feat(63, 1'b1);
        read_pair(0, 63);
        read_pair(63, 0);
        read_pair(63, 63);
        add_feat(42, 1'b1);
        read_pair(42, 42);

        // size one: bad index on add and read, row end on a failed add
        settle();
        write_size(1);
        add_feat(0, 1'b0);
        add_feat(1, 1'b1);
        read_pair(0, 1);
        read_pair(1, 0);
        read_pair(0, 0);

        // zero size rejects everything
        settle();
        write_size(0);
        add_feat(0, 1'b1);
        read_pair(0, 0);

        // oversize acts as the full matrix
        settle();
        write_size(127);
        read_pair(63, 63);
        add_feat(63, 1'b1);
        read_pair(63, 63);

        settle();
        write_size(64);
        run_rows(150);

        settle();
        write_size($urandom_range(2, 63));
        in_gap_pct  = 77;
        out_gap_pct = 6;
        run_rows(150);

        settle();
        write_size($urandom_range(65, 126));
        in_gap_pct  = 0;
        out_gap_pct = 0;
        hold_off    = 1'b1;
        run_rows(150);

        in_valid = 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0)
            $display("feature_pair_coincidence_counter_top test passed");
        else
            $display("feature_pair_coincidence_counter_top test failed");
        $finish;
    end

endmodule
